// ===== sv/pinhole_reprojection_error_assert.svh =====
// Assertion macros for the reprojection block
`ifndef PINHOLE_REPROJECTION_ERROR_ASSERT_SVH
`define PINHOLE_REPROJECTION_ERROR_ASSERT_SVH

`define PRJ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PRJ_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/prj_pkg.sv =====
`timescale 1ns / 1ps
package prj_pkg;

   localparam int DIV_QBITS = 35;
   localparam int SQRT_BITS = 32;
   localparam logic [DIV_QBITS-1:0] Q_LIMIT = 35'h4_0000_0000;

   typedef enum logic [2:0] {
      CSR_FOCAL_X  = 3'd0,
      CSR_FOCAL_Y  = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_WIDTH    = 3'd4,
      CSR_HEIGHT   = 3'd5
   } csr_index_type;

endpackage

// ===== sv/prj_div.sv =====
`timescale 1ns / 1ps
module prj_div
   import prj_pkg::*;
#(
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 vld_i,
   input  logic [63:0]          num_i,
   input  logic [30:0]          den_i,
   input  logic [SW-1:0]        side_i,
   output logic                 vld_o,
   output logic [DIV_QBITS-1:0] quo_o,
   output logic                 sat_o,
   output logic [SW-1:0]        side_o
);

   logic                 vld_ff  [0:DIV_QBITS];
   logic [30:0]          rem_ff  [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] low_ff  [0:DIV_QBITS];
   logic [DIV_QBITS-1:0] quo_ff  [0:DIV_QBITS];
   logic [30:0]          den_ff  [0:DIV_QBITS];
   logic                 sat_ff  [0:DIV_QBITS];
   logic [SW-1:0]        side_ff [0:DIV_QBITS];

   logic [30:0]          rem_in [1:DIV_QBITS];
   logic [DIV_QBITS-1:0] quo_in [1:DIV_QBITS];
   logic                 over_in;

   always_comb begin
      logic [31:0] t;
      logic        ge;
      over_in = ({3'b0, num_i[63:DIV_QBITS]} >= {1'b0, den_i});
      for (int k = 1; k <= DIV_QBITS; k++) begin
         t  = {rem_ff[k-1], low_ff[k-1][DIV_QBITS-1]};
         ge = (t >= {1'b0, den_ff[k-1]});
         rem_in[k] = ge ? 31'(t - {1'b0, den_ff[k-1]}) : t[30:0];
         quo_in[k] = {quo_ff[k-1][DIV_QBITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_QBITS; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int k = 1; k <= DIV_QBITS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= over_in ? 31'd0 : {2'b0, num_i[63:DIV_QBITS]};
         low_ff[0]  <= num_i[DIV_QBITS-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= den_i;
         sat_ff[0]  <= over_in;
         side_ff[0] <= side_i;
         for (int k = 1; k <= DIV_QBITS; k++) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= {low_ff[k-1][DIV_QBITS-2:0], 1'b0};
            quo_ff[k]  <= quo_in[k];
            den_ff[k]  <= den_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign vld_o  = vld_ff[DIV_QBITS];
   assign quo_o  = quo_ff[DIV_QBITS];
   assign sat_o  = sat_ff[DIV_QBITS];
   assign side_o = side_ff[DIV_QBITS];

endmodule

// ===== sv/prj_sqrt.sv =====
`timescale 1ns / 1ps
module prj_sqrt
   import prj_pkg::*;
#(
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 vld_i,
   input  logic [63:0]          rad_i,
   input  logic [SW-1:0]        side_i,
   output logic                 vld_o,
   output logic [SQRT_BITS-1:0] root_o,
   output logic [SW-1:0]        side_o
);

   logic                 vld_ff  [0:SQRT_BITS-1];
   logic [33:0]          rem_ff  [0:SQRT_BITS-1];
   logic [SQRT_BITS-1:0] root_ff [0:SQRT_BITS-1];
   logic [63:0]          rad_ff  [0:SQRT_BITS-1];
   logic [SW-1:0]        side_ff [0:SQRT_BITS-1];

   logic [33:0]          rem_in  [0:SQRT_BITS-1];
   logic [SQRT_BITS-1:0] root_in [0:SQRT_BITS-1];

   always_comb begin
      logic [33:0]          r2;
      logic [33:0]          t;
      logic [33:0]          prem;
      logic [SQRT_BITS-1:0] proot;
      logic [63:0]          prad;
      logic                 ge;
      for (int k = 0; k < SQRT_BITS; k++) begin
         if (k == 0) begin
            prem  = '0;
            proot = '0;
            prad  = rad_i;
         end else begin
            prem  = rem_ff[k-1];
            proot = root_ff[k-1];
            prad  = rad_ff[k-1];
         end
         r2 = {prem[31:0], prad[63:62]};
         t  = {proot, 2'b01};
         ge = (r2 >= t);
         rem_in[k]  = ge ? (r2 - t) : r2;
         root_in[k] = {proot[SQRT_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_BITS; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int k = 1; k < SQRT_BITS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= {rad_i[61:0], 2'b00};
         side_ff[0] <= side_i;
         for (int k = 1; k < SQRT_BITS; k++) begin
            rad_ff[k]  <= {rad_ff[k-1][61:0], 2'b00};
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < SQRT_BITS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign vld_o  = vld_ff[SQRT_BITS-1];
   assign root_o = root_ff[SQRT_BITS-1];
   assign side_o = side_ff[SQRT_BITS-1];

endmodule

// ===== sv/pinhole_reprojection_error.sv =====
`timescale 1ns / 1ps
// Pinhole projection of camera-frame points with reprojection error. One beat
// is taken per clock unless the output stalls. Stages: input register, focal
// multiply, a 36-stage divider (a quotient bit per stage but the first), center
// add, difference, squaring, sum, a 32-stage square root (one root bit per
// stage), output register. The pipeline advances as a whole; it holds while a
// result beat waits on rsp_tready. Configure only while no beat is in flight.
`include "pinhole_reprojection_error_assert.svh"
module pinhole_reprojection_error
   import prj_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // cam_x, cam_y, cam_z, obs_u, obs_v
   input  logic [159:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pix_u, pix_v, reproj_error, depth_out
   output logic [127:0]  rsp_tdata,
   // valid_res, inside_res
   output logic [1:0]    rsp_tuser,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   logic [31:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [15:0] width_ff, height_ff;
   logic        en;
   logic        nocheck;

   assign csr_pready = 1'b1;
   assign nocheck    = (width_ff == 16'd0) || (height_ff == 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= '0;
         focal_y_ff  <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[4:2])
            CSR_FOCAL_X:  focal_x_ff  <= csr_pwdata;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_pwdata;
            CSR_CENTER_X: center_x_ff <= csr_pwdata;
            CSR_CENTER_Y: center_y_ff <= csr_pwdata;
            CSR_WIDTH:    width_ff    <= csr_pwdata[15:0];
            CSR_HEIGHT:   height_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         CSR_FOCAL_X:  csr_prdata = focal_x_ff;
         CSR_FOCAL_Y:  csr_prdata = focal_y_ff;
         CSR_CENTER_X: csr_prdata = center_x_ff;
         CSR_CENTER_Y: csr_prdata = center_y_ff;
         CSR_WIDTH:    csr_prdata = {16'd0, width_ff};
         CSR_HEIGHT:   csr_prdata = {16'd0, height_ff};
         default:      csr_prdata = '0;
      endcase
   end

   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;

   // input stage
   logic        s0_vld_ff;
   logic [31:0] s0_x_ff, s0_y_ff, s0_z_ff, s0_ou_ff, s0_ov_ff;

   // multiply stage
   logic        s1_vld_ff, s1_pos_ff, s1_nx_ff, s1_ny_ff;
   logic [63:0] s1_px_ff, s1_py_ff;
   logic [30:0] s1_den_ff;
   logic [31:0] s1_z_ff, s1_ou_ff, s1_ov_ff;

   logic [31:0] ax_in, ay_in;
   assign ax_in = s0_x_ff[31] ? 32'(-s0_x_ff) : s0_x_ff;
   assign ay_in = s0_y_ff[31] ? 32'(-s0_y_ff) : s0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff   <= req_tdata[31:0];
         s0_y_ff   <= req_tdata[63:32];
         s0_z_ff   <= req_tdata[95:64];
         s0_ou_ff  <= req_tdata[127:96];
         s0_ov_ff  <= req_tdata[159:128];
         s1_pos_ff <= !s0_z_ff[31] && (s0_z_ff != 32'd0);
         s1_nx_ff  <= s0_x_ff[31];
         s1_ny_ff  <= s0_y_ff[31];
         s1_px_ff  <= 64'(focal_x_ff) * 64'(ax_in);
         s1_py_ff  <= 64'(focal_y_ff) * 64'(ay_in);
         s1_den_ff <= (!s0_z_ff[31] && (s0_z_ff != 32'd0)) ? s0_z_ff[30:0] : 31'd1;
         s1_z_ff   <= s0_z_ff;
         s1_ou_ff  <= s0_ou_ff;
         s1_ov_ff  <= s0_ov_ff;
      end
   end

   // divide
   logic                 dx_vld, dx_sat, dy_vld, dy_sat, dy_ny;
   logic [DIV_QBITS-1:0] dx_q, dy_q;
   logic [97:0]          dx_side;

   prj_div #(.SW(98)) u_div_x (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (s1_vld_ff), .num_i (s1_px_ff), .den_i (s1_den_ff),
      .side_i ({s1_pos_ff, s1_nx_ff, s1_z_ff, s1_ou_ff, s1_ov_ff}),
      .vld_o (dx_vld), .quo_o (dx_q), .sat_o (dx_sat), .side_o (dx_side)
   );

   prj_div #(.SW(1)) u_div_y (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (s1_vld_ff), .num_i (s1_py_ff), .den_i (s1_den_ff),
      .side_i (s1_ny_ff),
      .vld_o (dy_vld), .quo_o (dy_q), .sat_o (dy_sat), .side_o (dy_ny)
   );

   function automatic logic [31:0] add_center(input logic [DIV_QBITS-1:0] q,
                                              input logic sat, input logic neg,
                                              input logic [31:0] c);
      logic [DIV_QBITS-1:0] qc;
      logic [DIV_QBITS:0]   s;
      logic [36:0]          sum;
      qc  = (sat || (q > Q_LIMIT)) ? Q_LIMIT : q;
      s   = neg ? (DIV_QBITS+1)'(-{1'b0, qc}) : {1'b0, qc};
      sum = 37'(signed'(s)) + 37'(signed'(c));
      if (!sum[36] && (sum[35:31] != 5'd0)) return 32'h7FFF_FFFF;
      if (sum[36] && (sum[35:31] != 5'h1F)) return 32'h8000_0000;
      return sum[31:0];
   endfunction

   // center add stage
   logic        s2_vld_ff, s2_pos_ff;
   logic [31:0] s2_u_ff, s2_v_ff, s2_z_ff, s2_ou_ff, s2_ov_ff;

   // difference stage
   logic        s3_vld_ff, s3_pos_ff, s3_inside_ff, s3_big_ff;
   logic [31:0] s3_u_ff, s3_v_ff, s3_z_ff, s3_a_ff, s3_b_ff;

   // square stage
   logic        s4_vld_ff, s4_pos_ff, s4_inside_ff, s4_big_ff;
   logic [31:0] s4_u_ff, s4_v_ff, s4_z_ff;
   logic [63:0] s4_a2_ff, s4_b2_ff;

   // sum stage
   logic        s5_vld_ff, s5_pos_ff, s5_inside_ff, s5_ovf_ff;
   logic [31:0] s5_u_ff, s5_v_ff, s5_z_ff;
   logic [63:0] s5_s_ff;

   logic [32:0] du_in, dv_in, adu_in, adv_in;
   logic        inside_in;
   assign du_in  = 33'(signed'(s2_u_ff)) - 33'(signed'(s2_ou_ff));
   assign dv_in  = 33'(signed'(s2_v_ff)) - 33'(signed'(s2_ov_ff));
   assign adu_in = du_in[32] ? 33'(-du_in) : du_in;
   assign adv_in = dv_in[32] ? 33'(-dv_in) : dv_in;

   always_comb begin
      logic in_u, in_v;
      in_u = !s2_u_ff[31] && (64'(s2_u_ff[30:0]) < (64'(width_ff) << FRAC_BITS));
      in_v = !s2_v_ff[31] && (64'(s2_v_ff[30:0]) < (64'(height_ff) << FRAC_BITS));
      inside_in = nocheck || (s2_pos_ff && in_u && in_v);
   end

   logic [64:0] sum_in;
   assign sum_in = {1'b0, s4_a2_ff} + {1'b0, s4_b2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= dx_vld && dy_vld;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pos_ff <= dx_side[97];
         s2_u_ff   <= add_center(dx_q, dx_sat, dx_side[96], center_x_ff);
         s2_v_ff   <= add_center(dy_q, dy_sat, dy_ny, center_y_ff);
         s2_z_ff   <= dx_side[95:64];
         s2_ou_ff  <= dx_side[63:32];
         s2_ov_ff  <= dx_side[31:0];

         s3_pos_ff    <= s2_pos_ff;
         s3_inside_ff <= inside_in;
         s3_big_ff    <= adu_in[32] || adv_in[32];
         s3_u_ff      <= s2_pos_ff ? s2_u_ff : 32'd0;
         s3_v_ff      <= s2_pos_ff ? s2_v_ff : 32'd0;
         s3_z_ff      <= s2_z_ff;
         s3_a_ff      <= adu_in[31:0];
         s3_b_ff      <= adv_in[31:0];

         s4_pos_ff    <= s3_pos_ff;
         s4_inside_ff <= s3_inside_ff;
         s4_big_ff    <= s3_big_ff;
         s4_u_ff      <= s3_u_ff;
         s4_v_ff      <= s3_v_ff;
         s4_z_ff      <= s3_z_ff;
         s4_a2_ff     <= 64'(s3_a_ff) * 64'(s3_a_ff);
         s4_b2_ff     <= 64'(s3_b_ff) * 64'(s3_b_ff);

         s5_pos_ff    <= s4_pos_ff;
         s5_inside_ff <= s4_inside_ff;
         s5_ovf_ff    <= s4_big_ff || sum_in[64];
         s5_u_ff      <= s4_u_ff;
         s5_v_ff      <= s4_v_ff;
         s5_z_ff      <= s4_z_ff;
         s5_s_ff      <= sum_in[63:0];
      end
   end

   // square root
   logic                 sq_vld;
   logic [SQRT_BITS-1:0] sq_root;
   logic [98:0]          sq_side;

   prj_sqrt #(.SW(99)) u_sqrt (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (s5_vld_ff), .rad_i (s5_s_ff),
      .side_i ({s5_pos_ff, s5_inside_ff, s5_ovf_ff, s5_u_ff, s5_v_ff, s5_z_ff}),
      .vld_o (sq_vld), .root_o (sq_root), .side_o (sq_side)
   );

   logic [127:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;
   logic [31:0]  err_in;
   assign err_in = !sq_side[98] ? 32'd0 : (sq_side[96] ? 32'hFFFF_FFFF : sq_root);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {sq_side[31:0], err_in, sq_side[63:32], sq_side[95:64]};
         rsp_user_ff <= {sq_side[97], sq_side[98]};
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   `PRJ_ASSERT(a_invalid_zero, clock, reset,
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[95:0] == 96'd0), "invalid point not zeroed")
   `PRJ_ASSERT(a_nocheck_inside, clock, reset,
      (rsp_tvalid && (width_ff == 16'd0)) |-> rsp_tuser[1], "bounds check not disabled")
   `PRJ_ASSERT_NEXT(a_stall_hold, clock, reset,
      (rsp_tvalid && !rsp_tready), ($stable(rsp_tdata) && rsp_tvalid),
      "pipeline moved during stall")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
   import prj_pkg::*;
();

   typedef struct packed {
      logic        valid_res;
      logic [31:0] pix_u;
      logic [31:0] pix_v;
      logic [31:0] reproj_error;
      logic [31:0] depth_out;
      logic        inside_res;
   } proj_result_type;

   typedef struct {
      logic [31:0] cx, cy, cz, ou, ov;
      logic        has_exp;
      proj_result_type exp;
   } point_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   pinhole_reprojection_error u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [31:0] fx_q, fy_q, ctr_x_q, ctr_y_q;
   logic [15:0] img_w_q, img_h_q;
   proj_result_type pending_px[$];
   int  n_fail = 0;
   int  cycles = 0;
   int  rsp_wait = 0;
   bit  hold_rsp = 1'b0;
   bit  stim_done = 1'b0;

   function automatic longint sat_s32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint proj_axis(logic [31:0] f, logic [31:0] c,
                                         logic [31:0] z, logic [31:0] ctr);
      longint cs;
      logic [63:0] mag, q;
      longint s;
      cs  = longint'($signed(c));
      mag = (cs < 0) ? 64'(-cs) : 64'(cs);
      q   = (64'(f) * mag) / 64'(longint'($signed(z)));
      if (q > 64'h4_0000_0000) q = 64'h4_0000_0000;
      s = (cs < 0) ? -longint'(q) : longint'(q);
      return sat_s32(s + longint'($signed(ctr)));
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] pixel_dist(longint du, longint dv);
      logic [63:0] a, b, a2, b2, s, root;
      a = (du < 0) ? 64'(-du) : 64'(du);
      b = (dv < 0) ? 64'(-dv) : 64'(dv);
      if (a > 64'hFFFF_FFFF || b > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      a2 = a * a;
      b2 = b * b;
      s  = a2 + b2;
      if (s < a2) return 32'hFFFF_FFFF;
      root = int_sqrt(s);
      return root[31:0];
   endfunction

   function automatic proj_result_type project_point(logic [31:0] cx, logic [31:0] cy,
                                                     logic [31:0] cz, logic [31:0] ou,
                                                     logic [31:0] ov);
      proj_result_type r;
      longint u, v;
      bit nocheck;
      u = 0;
      v = 0;
      r = '0;
      nocheck = (img_w_q == 0) || (img_h_q == 0);
      if ($signed(cz) >= 1) begin
         r.valid_res = 1'b1;
         u = proj_axis(fx_q, cx, cz, ctr_x_q);
         v = proj_axis(fy_q, cy, cz, ctr_y_q);
         r.reproj_error = pixel_dist(u - longint'($signed(ou)),
                                     v - longint'($signed(ov)));
      end
      if (nocheck) r.inside_res = 1'b1;
      else if (!r.valid_res) r.inside_res = 1'b0;
      else r.inside_res = (u >= 0 && u < (longint'(img_w_q) << 16) &&
                           v >= 0 && v < (longint'(img_h_q) << 16));
      r.pix_u = u[31:0];
      r.pix_v = v[31:0];
      r.depth_out = cz;
      return r;
   endfunction

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(idx) << 2;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_FOCAL_X:  fx_q    = val;
         CSR_FOCAL_Y:  fy_q    = val;
         CSR_CENTER_X: ctr_x_q = val;
         CSR_CENTER_Y: ctr_y_q = val;
         CSR_WIDTH:    img_w_q = val[15:0];
         CSR_HEIGHT:   img_h_q = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                             logic [31:0] cy, logic [15:0] w, logic [15:0] h);
      wait (pending_px.size() == 0);
      repeat (90) @(posedge clock);
      csr_write(CSR_FOCAL_X, fx);
      csr_write(CSR_FOCAL_Y, fy);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_WIDTH, {16'h0, w});
      csr_write(CSR_HEIGHT, {16'h0, h});
   endtask

   task automatic send_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] ou, logic [31:0] ov, bit gaps);
      int g;
      g = gaps ? $urandom_range(0, 18) : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ov, ou, cz, cy, cx};
      do @(posedge clock); while (!req_tready);
      pending_px.push_back(project_point(cx, cy, cz, ou, ov));
   endtask

   task automatic send_row(point_row_type r, bit gaps);
      send_point(r.cx, r.cy, r.cz, r.ou, r.ov, gaps);
      if (r.has_exp) pending_px[pending_px.size() - 1] = r.exp;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000) <<< 8;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_depth();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return 32'($urandom_range(0, 3)) - 32'd1;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = $urandom_range(0, 18);
         rsp_tready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
         rsp_tready <= (rsp_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      proj_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32],
                rsp_tdata[95:64], rsp_tdata[127:96], rsp_tuser[1]};
         if (pending_px.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, got);
            n_fail++;
         end else begin
            want = pending_px.pop_front();
            if (got.valid_res !== want.valid_res) begin
               $display("%0t: valid_res expected %b actual %b", $time,
                        want.valid_res, got.valid_res);
               n_fail++;
            end
            if (got.pix_u !== want.pix_u) begin
               $display("%0t: pix_u expected %h actual %h", $time, want.pix_u, got.pix_u);
               n_fail++;
            end
            if (got.pix_v !== want.pix_v) begin
               $display("%0t: pix_v expected %h actual %h", $time, want.pix_v, got.pix_v);
               n_fail++;
            end
            if (got.reproj_error !== want.reproj_error) begin
               $display("%0t: reproj_error expected %h actual %h", $time,
                        want.reproj_error, got.reproj_error);
               n_fail++;
            end
            if (got.depth_out !== want.depth_out) begin
               $display("%0t: depth_out expected %h actual %h", $time,
                        want.depth_out, got.depth_out);
               n_fail++;
            end
            if (got.inside_res !== want.inside_res) begin
               $display("%0t: inside_res expected %b actual %b", $time,
                        want.inside_res, got.inside_res);
               n_fail++;
            end
         end
      end
   end

   initial begin
      wait (cycles == 400000);
      $display("Some tests failed");
      $finish;
   end

   point_row_type rows[$];

   function automatic point_row_type mk_row(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz, logic [31:0] ou,
                                            logic [31:0] ov, bit he, proj_result_type e);
      point_row_type r;
      r.cx = cx; r.cy = cy; r.cz = cz; r.ou = ou; r.ov = ov;
      r.has_exp = he; r.exp = e;
      return r;
   endfunction

   initial begin
      proj_result_type e;
      fx_q = 0; fy_q = 0; ctr_x_q = 0; ctr_y_q = 0; img_w_q = 0; img_h_q = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: valid point projects to zero, inside forced
      e = '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1};
      rows.push_back(mk_row(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 1, e));
      e = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1};
      rows.push_back(mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 0, 1, e));
      e = '{1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1};
      rows.push_back(mk_row(32'h1, 32'h1, 32'hFFFF_FFFF, 0, 0, 1, e));
      e = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1};
      rows.push_back(mk_row(0, 0, 32'h8000_0000, 0, 0, 1, e));
      e = '{1'b1, 32'h0, 32'h0, 32'hB504_F333, 32'h1, 1'b1};
      rows.push_back(mk_row(0, 0, 32'h1, 32'h8000_0000, 32'h8000_0000, 1, e));
      foreach (rows[i]) send_row(rows[i], 1'b0);
      req_tvalid <= 1'b0;

      // extreme focal and center, bounds enabled
      set_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 16'hFFFF, 16'hFFFF);
      rows = {};
      rows.push_back(mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 0, 0, 0, e));
      rows.push_back(mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, e));
      rows.push_back(mk_row(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 0, e));
      e = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0};
      rows.push_back(mk_row(32'h1, 32'h1, 32'h0, 0, 0, 1, e));
      foreach (rows[i]) send_row(rows[i], 1'b0);
      req_tvalid <= 1'b0;

      // 640x480 camera, points inside and well outside the image
      set_camera(32'h0200_0000, 32'h0200_0000, 32'h0140_0000, 32'h00F0_0000,
                 16'd640, 16'd480);
      rows = {};
      rows.push_back(mk_row(32'hFFF6_0000, 32'hFFF8_8000, 32'h0002_0000, 0, 0, 0, e));
      rows.push_back(mk_row(32'h000A_0000, 32'h0007_8000, 32'h0002_0000, 0, 0, 0, e));
      rows.push_back(mk_row(32'h0009_FFFF, 32'h0007_7FFF, 32'h0002_0000,
                            32'h0280_0000, 32'h01E0_0000, 0, e));
      rows.push_back(mk_row(32'hFFF5_FFFF, 0, 32'h0002_0000, 0, 0, 0, e));
      rows.push_back(mk_row(0, 32'hFFF8_7FFF, 32'h0002_0000, 0, 0, 0, e));
      rows.push_back(mk_row(32'h0001_2345, 32'hFFFF_0000, 32'h0003_0000,
                            32'h0141_0000, 32'h00EF_0000, 0, e));
      foreach (rows[i]) send_row(rows[i], 1'b1);
      req_tvalid <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_camera(32'h01F4_0000, 32'h01F4_0000, 32'h0140_0000, 32'h00F0_0000,
                          16'd640, 16'd480);
            1: set_camera($urandom(), $urandom(), $urandom(), $urandom(),
                          16'($urandom()), 16'($urandom()));
            2: set_camera(32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 16'd0);
            default: set_camera($urandom_range(32'h0010_0000, 32'h0400_0000),
                                $urandom_range(32'h0010_0000, 32'h0400_0000),
                                $urandom_range(0, 32'h0300_0000),
                                $urandom_range(0, 32'h0300_0000),
                                16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)));
         endcase
         if (ph == 1) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 1'b0;
               end
               for (int k = 0; k < 100; k++)
                  send_point(rand_coord(), rand_coord(), rand_depth(),
                             rand_coord(), rand_coord(), k % 25 > 12);
            join
         end else begin
            for (int k = 0; k < 100; k++)
               send_point(rand_coord(), rand_coord(), rand_depth(),
                          rand_coord(), rand_coord(), k % 30 > 8);
         end
         req_tvalid <= 1'b0;
      end

      wait (pending_px.size() == 0);
      repeat (100) @(posedge clock);
      if (n_fail == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
